>>> sv/rtc3w_pkg.sv
// Shared types and constants for the three-wire RTC serial master.
package rtc3w_pkg;

  // Request codes carried in the kind field
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [15:0] HALF_RESET = 16'd10;
  localparam logic [4:0]  NUM_SLOTS  = 5'd16;
  localparam logic [4:0]  FIRST_DATA_SLOT = 5'd8;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SETUP     = 3'd1,
    PH_ENABLE    = 3'd2,
    PH_LOW       = 3'd3,
    PH_HIGH      = 3'd4,
    PH_STOP_LOW  = 3'd5,
    PH_STOP_HIGH = 3'd6
  } rtc3w_phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] command;
    logic [7:0] write_data;
    logic       io_in;
  } rtc3w_item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } rtc3w_res_t;

  typedef struct packed {
    rtc3w_phase_e phase;
    logic [4:0]   bit_index;
    logic [15:0]  tick_count;
    logic [15:0]  shift_out;
    logic [7:0]   shift_in;
    logic         read_mode;
    logic         enable_level;
    logic         clock_level;
  } rtc3w_state_t;

endpackage

>>> sv/rtc3w_if.sv
// Valid/ready channel interfaces for tick words and result words.
interface rtc3w_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] command;
  logic [7:0] write_data;
  logic       io_in;

  modport source (output valid, kind, command, write_data, io_in, input ready);
  modport sink   (input valid, kind, command, write_data, io_in, output ready);
endinterface

interface rtc3w_out_if;
  logic       valid;
  logic       ready;
  logic       chip_enable;
  logic       serial_clock;
  logic       io_out;
  logic       io_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;

  modport source (output valid, chip_enable, serial_clock, io_out, io_drive, busy_res,
                  done_res, read_data, input ready);
  modport sink   (input valid, chip_enable, serial_clock, io_out, io_drive, busy_res,
                  done_res, read_data, output ready);
endinterface

>>> sv/rtc3w_step.sv
// Next-state and pin-level logic for one tick of the serial master.
module rtc3w_step (
  input  rtc3w_pkg::rtc3w_state_t state_i,
  input  rtc3w_pkg::rtc3w_item_t  item_i,
  input  logic [15:0]             half_i,
  output rtc3w_pkg::rtc3w_state_t state_o,
  output rtc3w_pkg::rtc3w_res_t   res_o
);
  import rtc3w_pkg::*;

  logic [15:0]  h;
  logic [15:0]  cnt;
  logic         done;
  logic         released;
  rtc3w_state_t ns;

  assign h = (half_i == 16'd0) ? 16'd1 : half_i;

  always_comb begin
    ns   = state_i;
    done = 1'b0;
    cnt  = state_i.tick_count + 16'd1;
    if (state_i.phase == PH_IDLE) begin
      if (item_i.kind == KIND_WRITE || item_i.kind == KIND_READ) begin
        ns.read_mode    = (item_i.kind == KIND_READ);
        ns.shift_out    = {(ns.read_mode ? 8'd0 : item_i.write_data), item_i.command};
        if (ns.read_mode) begin
          ns.shift_in = 8'd0;
        end
        ns.bit_index    = 5'd0;
        ns.tick_count   = 16'd0;
        ns.enable_level = 1'b0;
        ns.clock_level  = 1'b0;
        ns.phase        = PH_SETUP;
      end
    end else if (cnt >= h) begin
      ns.tick_count = 16'd0;
      case (state_i.phase)
        PH_SETUP: begin
          ns.enable_level = 1'b1;
          ns.phase        = PH_ENABLE;
        end
        PH_ENABLE: begin
          ns.clock_level = 1'b0;
          ns.phase       = PH_LOW;
        end
        PH_LOW: begin
          // sample just before the rising edge
          if (state_i.read_mode && state_i.bit_index >= FIRST_DATA_SLOT) begin
            ns.shift_in = {item_i.io_in, state_i.shift_in[7:1]};
          end
          ns.clock_level = 1'b1;
          ns.phase       = PH_HIGH;
        end
        PH_HIGH: begin
          ns.bit_index   = state_i.bit_index + 5'd1;
          ns.clock_level = 1'b0;
          ns.phase       = (ns.bit_index >= NUM_SLOTS) ? PH_STOP_LOW : PH_LOW;
        end
        PH_STOP_LOW: begin
          ns.clock_level = 1'b1;
          ns.phase       = PH_STOP_HIGH;
        end
        default: begin
          ns.enable_level = 1'b0;
          ns.clock_level  = 1'b1;
          ns.bit_index    = 5'd0;
          ns.phase        = PH_IDLE;
          done            = 1'b1;
        end
      endcase
    end else begin
      ns.tick_count = cnt;
    end
  end

  assign released = ns.read_mode && (ns.bit_index >= FIRST_DATA_SLOT);

  always_comb begin
    res_o              = '0;
    res_o.chip_enable  = ns.enable_level;
    res_o.serial_clock = ns.clock_level;
    res_o.busy_res     = (ns.phase != PH_IDLE);
    res_o.done_res     = done;
    res_o.read_data    = ns.shift_in;
    if (ns.phase == PH_LOW || ns.phase == PH_HIGH) begin
      if (!released) begin
        res_o.io_drive = 1'b1;
        res_o.io_out   = ns.shift_out[ns.bit_index[3:0]];
      end
    end else if (ns.phase != PH_IDLE) begin
      res_o.io_drive = ns.read_mode ? (ns.phase == PH_SETUP || ns.phase == PH_ENABLE) : 1'b1;
    end
  end

  assign state_o = ns;

endmodule

>>> sv/three_wire_rtc_serial_master_top.sv
// Top level of the three-wire RTC serial master: channels, registers, config.
//
// Usage
//   in_i  : one word per timing tick. kind selects plain tick, start write or
//           start read; command, write_data and the sampled data line ride along.
//           A start word is honored only while no transfer runs.
//   out_o : one word per input word with the pin levels after that tick
//           (chip enable, serial clock, data out, data drive), busy, a done
//           pulse and the read byte being assembled.
//   cfg_we_i / cfg_wdata_i : half_period_ticks, the length in ticks of every
//           transfer phase and clock half; zero behaves as one. Write it only
//           while the channels are quiet.
// Timing
//   A taken word sits in the input register, goes through the step logic into
//   the result register once that register can advance, and is offered from
//   then on. One word per cycle is sustained while the sink takes every result;
//   the combinational state update in the step logic is what sets that rate.
// Reset
//   Transfer state idle, enable and clock low, read byte zero, half period 10.
// Stall
//   A held result keeps its value; one more word waits in the input register
//   and in_i.ready drops until the sink takes the result.
module three_wire_rtc_serial_master_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtc3w_in_if.sink    in_i,
  rtc3w_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import rtc3w_pkg::*;

  logic         in_vld_q;
  rtc3w_item_t  in_q;
  logic         out_vld_q;
  rtc3w_res_t   out_q;
  rtc3w_state_t state_q;
  rtc3w_state_t state_d;
  rtc3w_res_t   res_d;
  logic [15:0]  half_q;
  logic         adv;
  logic         in_take;

  // Result stage moves when empty or drained this cycle.
  assign adv     = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || adv;
  assign in_take = in_i.valid && in_i.ready;

  rtc3w_step u_step (
    .state_i (state_q),
    .item_i  (in_q),
    .half_i  (half_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      half_q    <= HALF_RESET;
      state_q   <= '{phase: PH_IDLE, default: '0};
    end else begin
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
        if (in_vld_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.kind       <= in_i.kind;
      in_q.command    <= in_i.command;
      in_q.write_data <= in_i.write_data;
      in_q.io_in      <= in_i.io_in;
    end
    if (adv && in_vld_q) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.chip_enable  = out_q.chip_enable;
  assign out_o.serial_clock = out_q.serial_clock;
  assign out_o.io_out       = out_q.io_out;
  assign out_o.io_drive     = out_q.io_drive;
  assign out_o.busy_res     = out_q.busy_res;
  assign out_o.done_res     = out_q.done_res;
  assign out_o.read_data    = out_q.read_data;

  // Idle implies the slot counter was rewound.
  a_idle_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE |-> state_q.bit_index == 5'd0)
    else $error("slot counter not zero while idle");

  // Slot counter never exceeds the slot count.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_index <= NUM_SLOTS)
    else $error("slot counter out of range");

  // A finished transfer shows enable low, clock high and not busy.
  a_done_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.done_res |-> !out_q.busy_res && !out_q.chip_enable
                                    && out_q.serial_clock)
    else $error("done word with wrong pin levels");

  // State only moves when a word passes into the result register.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && in_vld_q) |=> $stable(state_q))
    else $error("transfer state changed without a word");

  // Busy in the result matches the registered phase.
  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_vld_q |=> out_q.busy_res == (state_q.phase != PH_IDLE))
    else $error("busy flag disagrees with phase");

endmodule

>>> dv/tb_top.sv
// Self-checking bench for the three-wire RTC serial master: directed plan, then random ticks.
`timescale 1ns / 1ps

module tb_top;
  import rtc3w_pkg::*;

  // kind 3 is not a request code; the block must treat it as a plain tick
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_WAIT = 18;
  localparam int MAX_SHOWN = 40;

  // Pin words that can be read straight off the protocol:
  // idle after reset, first setup tick of a write or read, parked after done.
  localparam rtc3w_res_t IDLE_PINS  = {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam rtc3w_res_t SETUP_PINS = {1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00};
  localparam rtc3w_res_t PARKED_FF  = {1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF};
  localparam rtc3w_res_t PARKED_00  = {1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};

  typedef enum logic {ROW_WORD, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e    op;
    logic [1:0] kind;
    logic [7:0] cmd;
    logic [7:0] wdat;
    logic       io;
    int         reps;
    logic [15:0] half;
    bit         typed;
    rtc3w_res_t pins;
  } plan_row_t;

  // Directed plan. Typed rows carry their pin word; the rest go through the model.
  plan_row_t plan [24] = '{
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b0,   1, 16'd0,     1'b1, IDLE_PINS},
    '{ROW_WORD, KIND_SPARE, 8'hFF, 8'hFF, 1'b1,   1, 16'd0,     1'b1, IDLE_PINS},
    '{ROW_CFG,  KIND_TICK,  8'h00, 8'h00, 1'b0,   0, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_WRITE, 8'hFF, 8'h00, 1'b0,   1, 16'd0,     1'b1, SETUP_PINS},
    '{ROW_WORD, KIND_READ,  8'h00, 8'h00, 1'b0,   1, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b1,  40, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_READ,  8'h00, 8'h00, 1'b1,   1, 16'd0,     1'b1, SETUP_PINS},
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b1,  40, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b1,   1, 16'd0,     1'b1, PARKED_FF},
    '{ROW_WORD, KIND_WRITE, 8'h00, 8'hFF, 1'b0,   1, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b0,  40, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b0,   1, 16'd0,     1'b1, PARKED_FF},
    '{ROW_WORD, KIND_READ,  8'h55, 8'h00, 1'b0,   1, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b0,  40, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b0,   1, 16'd0,     1'b1, PARKED_00},
    '{ROW_CFG,  KIND_TICK,  8'h00, 8'h00, 1'b0,   0, 16'hFFFF,  1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_WRITE, 8'hA5, 8'h5A, 1'b0,   1, 16'd0,     1'b1, SETUP_PINS},
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b1,  20, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_CFG,  KIND_TICK,  8'h00, 8'h00, 1'b0,   0, 16'd2,     1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_WRITE, 8'h3C, 8'hC3, 1'b1,   1, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b1, 100, 16'd0,     1'b0, IDLE_PINS},
    '{ROW_CFG,  KIND_TICK,  8'h00, 8'h00, 1'b0,   0, HALF_RESET, 1'b0, IDLE_PINS},
    '{ROW_WORD, KIND_READ,  8'h81, 8'h00, 1'b1,   1, 16'd0,     1'b1, SETUP_PINS},
    '{ROW_WORD, KIND_TICK,  8'h00, 8'h00, 1'b0,  30, 16'd0,     1'b0, IDLE_PINS}
  };

  // Random phases: half period and word count. Zero, one and the maximum are the extremes.
  localparam int NUM_PHASES = 7;
  logic [15:0] phase_half  [NUM_PHASES] = '{16'd1, 16'd0, 16'd2, 16'd3, 16'hFFFF, 16'd1, 16'd4};
  int          phase_words [NUM_PHASES] = '{120, 100, 100, 100, 30, 100, 30};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic res_ready = 1'b0;

  rtc3w_in_if  in_ch ();
  rtc3w_out_if out_ch ();

  assign out_ch.ready = res_ready;

  three_wire_rtc_serial_master_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Master model: own copy of the transfer state and the half period register.
  // ---------------------------------------------------------------------------
  rtc3w_phase_e m_phase;
  logic [4:0]   m_slot;
  logic [16:0]  m_ticks;
  logic [15:0]  m_shift_out;
  logic [7:0]   m_shift_in;
  logic         m_read;
  logic         m_enable;
  logic         m_sclk;
  logic [15:0]  m_half;

  rtc3w_res_t want_pins_q [$];   // pin words still owed by the block
  int fails;
  int words_sent;
  int writes_started;
  int reads_started;
  int dones_seen;
  int settings_used;
  int cycles;
  bit calm;                      // no idling on either side during this phase

  function automatic void master_reset();
    m_phase     = PH_IDLE;
    m_slot      = '0;
    m_ticks     = '0;
    m_shift_out = '0;
    m_shift_in  = '0;
    m_read      = 1'b0;
    m_enable    = 1'b0;
    m_sclk      = 1'b0;
    m_half      = HALF_RESET;
  endfunction

  // data half of a read: line belongs to the device
  function automatic bit line_released();
    return m_read && (m_slot >= FIRST_DATA_SLOT);
  endfunction

  // One tick of the master; returns the pin word after the tick.
  function automatic rtc3w_res_t advance_master(rtc3w_item_t w);
    rtc3w_res_t  r;
    logic [16:0] h;
    h = (m_half == 16'd0) ? 17'd1 : {1'b0, m_half};
    r = '0;
    if (m_phase == PH_IDLE) begin
      if (w.kind == KIND_WRITE || w.kind == KIND_READ) begin
        m_read      = (w.kind == KIND_READ);
        m_shift_out = m_read ? {8'h00, w.command} : {w.write_data, w.command};
        if (m_read) m_shift_in = '0;
        m_slot   = '0;
        m_ticks  = '0;
        m_enable = 1'b0;
        m_sclk   = 1'b0;
        m_phase  = PH_SETUP;
        if (m_read) reads_started++;
        else writes_started++;
      end
    end else begin
      m_ticks++;
      if (m_ticks >= h) begin
        m_ticks = '0;
        case (m_phase)
          PH_SETUP: begin
            m_enable = 1'b1;
            m_phase  = PH_ENABLE;
          end
          PH_ENABLE: begin
            m_sclk  = 1'b0;
            m_phase = PH_LOW;
          end
          PH_LOW: begin
            // sample on the last tick before the rising clock edge, LSB first
            if (line_released()) m_shift_in = {w.io_in, m_shift_in[7:1]};
            m_sclk  = 1'b1;
            m_phase = PH_HIGH;
          end
          PH_HIGH: begin
            m_slot++;
            m_sclk  = 1'b0;
            m_phase = (m_slot >= NUM_SLOTS) ? PH_STOP_LOW : PH_LOW;
          end
          PH_STOP_LOW: begin
            m_sclk  = 1'b1;
            m_phase = PH_STOP_HIGH;
          end
          default: begin
            // stop high done: enable drops, clock parks high
            m_enable   = 1'b0;
            m_sclk     = 1'b1;
            m_slot     = '0;
            m_phase    = PH_IDLE;
            r.done_res = 1'b1;
          end
        endcase
      end
    end

    if (m_phase == PH_LOW || m_phase == PH_HIGH) begin
      if (!line_released()) begin
        r.io_drive = 1'b1;
        r.io_out   = m_shift_out[m_slot[3:0]];
      end
    end else if (m_phase != PH_IDLE) begin
      // reads let go of the line once the command is out, stop phases included
      r.io_drive = m_read ? (m_phase == PH_SETUP || m_phase == PH_ENABLE) : 1'b1;
    end

    r.chip_enable  = m_enable;
    r.serial_clock = m_sclk;
    r.busy_res     = (m_phase != PH_IDLE);
    r.read_data    = m_shift_in;
    return r;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Mostly ticks with random line level; starts land whenever the master is idle,
  // and those that land mid-transfer check the ignore path.
  function automatic rtc3w_item_t rand_word();
    rtc3w_item_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)       w.kind = KIND_WRITE;
    else if (pick < 16) w.kind = KIND_READ;
    else if (pick < 19) w.kind = KIND_SPARE;
    else                w.kind = KIND_TICK;
    w.command    = 8'($urandom());
    w.write_data = 8'($urandom());
    w.io_in      = 1'($urandom());
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. valid stays up across back-to-back words; one NBA per edge.
  // ---------------------------------------------------------------------------
  task automatic send_word(input rtc3w_item_t w, input bit typed, input rtc3w_res_t pins);
    int gap;
    rtc3w_res_t got;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= w.kind;
    in_ch.command    <= w.command;
    in_ch.write_data <= w.write_data;
    in_ch.io_in      <= w.io_in;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    got = advance_master(w);
    want_pins_q.push_back(typed ? pins : got);
    words_sent++;
  endtask

  // Register write only with nothing in flight; the model follows at the same edge.
  task automatic set_half(input logic [15:0] value);
    in_ch.valid <= 1'b0;
    while (want_pins_q.size() != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    m_half = value;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall after every taken word, field-by-field check.
  // ---------------------------------------------------------------------------
  task automatic note_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fails++;
      if (fails <= MAX_SHOWN)
        $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  int stall_left;

  always @(posedge clk_i) begin
    rtc3w_res_t want;
    if (!rst_ni) begin
      res_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (want_pins_q.size() == 0) begin
          fails++;
          if (fails <= MAX_SHOWN)
            $display("%0t ns: unexpected word, expected none actual ce=%b sclk=%b rd=%0h",
                     $time, out_ch.chip_enable, out_ch.serial_clock, out_ch.read_data);
        end else begin
          want = want_pins_q.pop_front();
          note_field("chip_enable",  want.chip_enable,  out_ch.chip_enable);
          note_field("serial_clock", want.serial_clock, out_ch.serial_clock);
          note_field("io_out",       want.io_out,       out_ch.io_out);
          note_field("io_drive",     want.io_drive,     out_ch.io_drive);
          note_field("busy_res",     want.busy_res,     out_ch.busy_res);
          note_field("done_res",     want.done_res,     out_ch.done_res);
          note_field("read_data",    want.read_data,    out_ch.read_data);
        end
        if (out_ch.done_res) dones_seen++;
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Watchdog on a hung handshake
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles, want_pins_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed plan, random phases, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    rtc3w_item_t w;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_TICK;
    in_ch.command    <= '0;
    in_ch.write_data <= '0;
    in_ch.io_in      <= 1'b0;
    master_reset();
    calm = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        set_half(plan[i].half);
      end else begin
        w = {plan[i].kind, plan[i].cmd, plan[i].wdat, plan[i].io};
        repeat (plan[i].reps) send_word(w, plan[i].typed, plan[i].pins);
      end
    end

    // a transfer left running across a register write is intended: the new
    // half period takes over mid-phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_half(phase_half[p]);
      calm = ($urandom_range(0, 3) == 0);
      repeat (phase_words[p]) send_word(rand_word(), 1'b0, IDLE_PINS);
    end

    in_ch.valid <= 1'b0;
    while (want_pins_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d words over %0d half-period settings", words_sent, settings_used);
    $display("Transfers: %0d writes and %0d reads started, %0d done pulses seen",
             writes_started, reads_started, dones_seen);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches", fails);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
